// ===== hdl/sac_pkg.sv =====
// shared types for the swept box collision block
// no dependencies
`timescale 1ns / 1ps
package sac_pkg;

  localparam int unsigned TimeBits = 32;
  localparam int unsigned NumLanes = 4;

  // per-item flags that travel beside the divider lanes
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                zero_x;
    logic                zero_y;
    logic                ix_neg;
    logic                iy_neg;
    logic [NumLanes-1:0] neg;
  } meta_t;

endpackage

// ===== hdl/sac_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per register stage
// depends on sac_pkg
`timescale 1ns / 1ps
module sac_div #(
  parameter int unsigned NW  = 35,
  parameter int unsigned DVW = 16
) (
  input  logic           clk_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DVW-1:0] den_i,
  output logic [NW-1:0]  quo_o
);
  import sac_pkg::*;

  logic [DVW-1:0] rem_q [NW];
  logic [NW-1:0]  sh_q  [NW];
  logic [DVW-1:0] den_q [NW];
  logic [DVW-1:0] rem_in [NW];
  logic [NW-1:0]  sh_in  [NW];
  logic [DVW-1:0] den_in [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           ge;
    logic [DVW-1:0] rem_d;
    logic [NW-1:0]  sh_d;

    if (i == 0) begin : g_first
      assign rem_in[i] = '0;
      assign sh_in[i]  = num_i;
      assign den_in[i] = den_i;
    end else begin : g_next
      assign rem_in[i] = rem_q[i-1];
      assign sh_in[i]  = sh_q[i-1];
      assign den_in[i] = den_q[i-1];
    end

    always_comb begin
      trial = {rem_in[i], sh_in[i][NW-1]};
      diff  = trial - {1'b0, den_in[i]};
      ge    = (trial >= {1'b0, den_in[i]});
      rem_d = ge ? diff[DVW-1:0] : trial[DVW-1:0];
      // remaining dividend bits shift out the top, quotient bits fill in below
      sh_d  = {sh_in[i][NW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      sh_q[i]  <= sh_d;
      den_q[i] <= den_in[i];
    end
  end

  assign quo_o = sh_q[NW-1];

endmodule

// ===== hdl/swept_aabb_collision.sv =====
// swept box collision test, top level
// depends on sac_pkg and sac_div
`timescale 1ns / 1ps
// Takes one box pair in every cycle (busy_o stays low) and gives one result per
// pair, marked by valid_o for one cycle. The pipeline is built around the four
// restoring dividers, which resolve one quotient bit per register stage; one
// stage forms the distances before them and two stages saturate the times and
// choose the normal after them. Results cannot be held off.
module swept_aabb_collision #(
  parameter int unsigned COORD_BITS     = 16,
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] moving_x_i,
  input  logic signed [COORD_BITS-1:0] moving_y_i,
  input  logic        [COORD_BITS-2:0] moving_w_i,
  input  logic        [COORD_BITS-2:0] moving_h_i,
  input  logic signed [COORD_BITS-1:0] vel_x_i,
  input  logic signed [COORD_BITS-1:0] vel_y_i,
  input  logic signed [COORD_BITS-1:0] static_x_i,
  input  logic signed [COORD_BITS-1:0] static_y_i,
  input  logic        [COORD_BITS-2:0] static_w_i,
  input  logic        [COORD_BITS-2:0] static_h_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic signed [31:0]           entry_time_o,
  output logic signed [31:0]           exit_time_o,
  output logic signed [1:0]            normal_x_o,
  output logic signed [1:0]            normal_y_o
);
  import sac_pkg::*;

  localparam int unsigned DW = COORD_BITS + 3;
  localparam int unsigned NW = DW + TIME_FRAC_BITS;

  localparam logic signed [TimeBits-1:0] TMax = {1'b0, {(TimeBits-1){1'b1}}};
  localparam logic signed [TimeBits-1:0] TMin = {1'b1, {(TimeBits-1){1'b0}}};

  assign busy_o = 1'b0;

  // stage 1: distances and overlap
  logic signed [DW-1:0] m [2];
  logic signed [DW-1:0] sz [2];
  logic signed [DW-1:0] v [2];
  logic signed [DW-1:0] s [2];
  logic signed [DW-1:0] ss [2];
  logic signed [DW-1:0] far_m [2];
  logic signed [DW-1:0] far_s [2];
  logic signed [DW-1:0] d_en [2];
  logic signed [DW-1:0] d_ex [2];
  logic                 over [2];
  logic [DW-1:0]        mag_en [2];
  logic [DW-1:0]        mag_ex [2];
  logic [COORD_BITS-1:0] vmag [2];

  meta_t                 meta_d;
  meta_t                 meta1_q;
  logic [NW-1:0]         num1_q [NumLanes];
  logic [COORD_BITS-1:0] den1_q [NumLanes];

  always_comb begin
    m[0]  = DW'(moving_x_i);
    m[1]  = DW'(moving_y_i);
    sz[0] = $signed(DW'(moving_w_i));
    sz[1] = $signed(DW'(moving_h_i));
    v[0]  = DW'(vel_x_i);
    v[1]  = DW'(vel_y_i);
    s[0]  = DW'(static_x_i);
    s[1]  = DW'(static_y_i);
    ss[0] = $signed(DW'(static_w_i));
    ss[1] = $signed(DW'(static_h_i));
    for (int a = 0; a < 2; a++) begin
      far_m[a] = m[a] + sz[a] + v[a];
      far_s[a] = s[a] + ss[a];
      over[a]  = (m[a] < far_s[a]) && (far_m[a] > s[a]);
      if (v[a] > 0) begin
        d_en[a] = s[a] - far_m[a];
        d_ex[a] = far_s[a] - m[a];
      end else begin
        d_en[a] = far_s[a] - m[a];
        d_ex[a] = s[a] - far_m[a];
      end
      mag_en[a] = d_en[a][DW-1] ? DW'(-d_en[a]) : DW'(d_en[a]);
      mag_ex[a] = d_ex[a][DW-1] ? DW'(-d_ex[a]) : DW'(d_ex[a]);
      vmag[a]   = v[a][DW-1] ? COORD_BITS'(-v[a]) : COORD_BITS'(v[a]);
    end
    meta_d.valid  = start_i;
    meta_d.hit    = over[0] && over[1];
    meta_d.zero_x = (v[0] == '0);
    meta_d.zero_y = (v[1] == '0);
    meta_d.ix_neg = d_en[0][DW-1];
    meta_d.iy_neg = d_en[1][DW-1];
    meta_d.neg[0] = d_en[0][DW-1] ^ v[0][DW-1];
    meta_d.neg[1] = d_ex[0][DW-1] ^ v[0][DW-1];
    meta_d.neg[2] = d_en[1][DW-1] ^ v[1][DW-1];
    meta_d.neg[3] = d_ex[1][DW-1] ^ v[1][DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
    end else begin
      meta1_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num1_q[0] <= {mag_en[0], {TIME_FRAC_BITS{1'b0}}};
    num1_q[1] <= {mag_ex[0], {TIME_FRAC_BITS{1'b0}}};
    num1_q[2] <= {mag_en[1], {TIME_FRAC_BITS{1'b0}}};
    num1_q[3] <= {mag_ex[1], {TIME_FRAC_BITS{1'b0}}};
    den1_q[0] <= vmag[0];
    den1_q[1] <= vmag[0];
    den1_q[2] <= vmag[1];
    den1_q[3] <= vmag[1];
  end

  // dividers
  logic [NW-1:0] quo [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    sac_div #(
      .NW (NW),
      .DVW(COORD_BITS)
    ) u_div (
      .clk_i(clk_i),
      .num_i(num1_q[l]),
      .den_i(den1_q[l]),
      .quo_o(quo[l])
    );
  end

  // flags ride beside the divider stages
  meta_t meta_dl_q [NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) begin
        meta_dl_q[i] <= '0;
      end
    end else begin
      meta_dl_q[0] <= meta1_q;
      for (int i = 1; i < NW; i++) begin
        meta_dl_q[i] <= meta_dl_q[i-1];
      end
    end
  end

  // saturation stage
  function automatic logic signed [TimeBits-1:0] sat_time(input logic [NW-1:0] q,
                                                          input logic neg);
    logic [63:0] qe;
    logic [TimeBits-1:0] lo;
    qe = 64'(q);
    lo = qe[TimeBits-1:0];
    if (!neg) begin
      sat_time = (qe > 64'h7fff_ffff) ? TMax : $signed(lo);
    end else begin
      sat_time = (qe > 64'h8000_0000) ? TMin : $signed(-lo);
    end
  endfunction

  meta_t                       meta_s_q;
  logic signed [TimeBits-1:0]  t_d [NumLanes];
  logic signed [TimeBits-1:0]  t_q [NumLanes];
  meta_t                       meta_n;

  assign meta_n = meta_dl_q[NW-1];

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      t_d[l] = sat_time(quo[l], meta_n.neg[l]);
    end
    // an axis with no motion never starts and never ends
    if (meta_n.zero_x) begin
      t_d[0] = TMin;
      t_d[1] = TMax;
    end
    if (meta_n.zero_y) begin
      t_d[2] = TMin;
      t_d[3] = TMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_s_q <= '0;
    end else begin
      meta_s_q <= meta_n;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      t_q[l] <= t_d[l];
    end
  end

  // output stage: combine axes and pick the struck face
  logic                       x_face;
  logic                       hit_d;
  logic signed [TimeBits-1:0] entry_d;
  logic signed [TimeBits-1:0] exit_d;
  logic signed [1:0]          nx_d;
  logic signed [1:0]          ny_d;

  always_comb begin
    x_face  = (t_q[0] > t_q[2]);
    hit_d   = meta_s_q.hit;
    entry_d = '0;
    exit_d  = '0;
    nx_d    = '0;
    ny_d    = '0;
    if (meta_s_q.hit) begin
      entry_d = x_face ? t_q[0] : t_q[2];
      exit_d  = (t_q[1] < t_q[3]) ? t_q[1] : t_q[3];
      if (x_face) begin
        nx_d = meta_s_q.ix_neg ? 2'sb01 : 2'sb11;
      end else begin
        ny_d = meta_s_q.iy_neg ? 2'sb11 : 2'sb01;
      end
    end
  end

  logic                       valid_q;
  logic                       hit_q;
  logic signed [TimeBits-1:0] entry_q;
  logic signed [TimeBits-1:0] exit_q;
  logic signed [1:0]          nx_q;
  logic signed [1:0]          ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= meta_s_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    entry_q <= entry_d;
    exit_q  <= exit_d;
    nx_q    <= nx_d;
    ny_q    <= ny_d;
  end

  assign valid_o      = valid_q;
  assign hit_o        = hit_q;
  assign entry_time_o = entry_q;
  assign exit_time_o  = exit_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;

endmodule
